>>> hdl/ics_pkg.sv
`timescale 1ns / 1ps

package ics_pkg;

  // result event codes
  localparam logic [2:0] EV_RX_ACCEPTED  = 3'd0;
  localparam logic [2:0] EV_RX_REJECTED  = 3'd1;
  localparam logic [2:0] EV_CLOSED       = 3'd2;
  localparam logic [2:0] EV_TICK_IDLE    = 3'd3;
  localparam logic [2:0] EV_TX_SENT      = 3'd4;
  localparam logic [2:0] EV_TX_SUPPRESS  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_TIMEOUT_MULT   = 3'd0;
  localparam logic [2:0] CFG_CONSUME_IVL    = 3'd1;
  localparam logic [2:0] CFG_PRODUCE_IVL    = 3'd2;
  localparam logic [2:0] CFG_SEQUENCED      = 3'd3;
  localparam logic [2:0] CFG_RUN_HDR_MASK   = 3'd4;
  localparam logic [2:0] CFG_FIXED_MASK     = 3'd5;
  localparam logic [2:0] CFG_RX_EXP_SIZE    = 3'd6;
  localparam logic [2:0] CFG_TX_EXP_SIZE    = 3'd7;

  localparam logic       CMD_TICK  = 1'b0;
  localparam logic       CMD_FRAME = 1'b1;

  localparam logic [9:0]  US_PER_MS = 10'd1000;
  localparam logic [47:0] ACC_MAX   = 48'hFFFF_FFFF_FFFF;

  localparam int MICRO_W = 26;  // 65535 ms in microseconds fits 26 bits
  localparam int LIMIT_W = 42;  // 10-bit multiplier times 32-bit interval

  typedef struct packed {
    logic [LIMIT_W-1:0] timeout_limit;
    logic [31:0]        produce_interval;
    logic               seq_en;
    logic               rx_hdr_en;
    logic               tx_hdr_en;
    logic               rx_fixed;
    logic               tx_fixed;
    logic [15:0]        rx_expected_size;
    logic [15:0]        tx_expected_size;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [15:0] period_ms;
    logic [15:0] rx_total_length;
    logic [31:0] rx_run_header;
    logic [15:0] rx_seq_count;
    logic [15:0] tx_payload_length;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        alive;
    logic [15:0] payload_length;
    logic [31:0] delivered_run_header;
    logic [15:0] delivered_seq_count;
    logic [31:0] tx_sequence_number;
    logic [15:0] tx_seq_count;
    logic        tx_count_present;
    logic        tx_header_present;
  } res_t;

endpackage

>>> hdl/ics_intf.sv
`timescale 1ns / 1ps

interface ics_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] period_ms;
  logic [15:0] rx_total_length;
  logic [31:0] rx_run_header;
  logic [15:0] rx_seq_count;
  logic [15:0] tx_payload_length;

  modport source (output valid, command, period_ms, rx_total_length, rx_run_header,
                  rx_seq_count, tx_payload_length, input ready);
  modport sink (input valid, command, period_ms, rx_total_length, rx_run_header,
                rx_seq_count, tx_payload_length, output ready);
endinterface

interface ics_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic        alive;
  logic [15:0] payload_length;
  logic [31:0] delivered_run_header;
  logic [15:0] delivered_seq_count;
  logic [31:0] tx_sequence_number;
  logic [15:0] tx_seq_count;
  logic        tx_count_present;
  logic        tx_header_present;

  modport source (output valid, event_res, alive, payload_length, delivered_run_header,
                  delivered_seq_count, tx_sequence_number, tx_seq_count,
                  tx_count_present, tx_header_present, input ready);
  modport sink (input valid, event_res, alive, payload_length, delivered_run_header,
                delivered_seq_count, tx_sequence_number, tx_seq_count,
                tx_count_present, tx_header_present, output ready);
endinterface

interface ics_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/ics_cfg_regs.sv
`timescale 1ns / 1ps

module ics_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [2:0]    wr_index,
  input  logic [31:0]   wr_data,
  output ics_pkg::cfg_t cfg
);

  logic [9:0]                   mult_r,    mult_nxt;
  logic [31:0]                  consume_r, consume_nxt;
  logic [31:0]                  produce_r, produce_nxt;
  logic                         seq_r,     seq_nxt;
  logic [1:0]                   hdr_r,     hdr_nxt;
  logic [1:0]                   fixed_r,   fixed_nxt;
  logic [15:0]                  rx_exp_r,  rx_exp_nxt;
  logic [15:0]                  tx_exp_r,  tx_exp_nxt;
  logic [ics_pkg::LIMIT_W-1:0]  limit_r,   limit_nxt;
  logic [9:0]                   mul_a;
  logic [31:0]                  mul_b;

  assign wr_ready = 1'b1;

  always_comb begin
    mult_nxt    = mult_r;
    consume_nxt = consume_r;
    produce_nxt = produce_r;
    seq_nxt     = seq_r;
    hdr_nxt     = hdr_r;
    fixed_nxt   = fixed_r;
    rx_exp_nxt  = rx_exp_r;
    tx_exp_nxt  = tx_exp_r;
    if (wr_valid) begin
      case (wr_index)
        ics_pkg::CFG_TIMEOUT_MULT: mult_nxt    = wr_data[9:0];
        ics_pkg::CFG_CONSUME_IVL:  consume_nxt = wr_data;
        ics_pkg::CFG_PRODUCE_IVL:  produce_nxt = wr_data;
        ics_pkg::CFG_SEQUENCED:    seq_nxt     = wr_data[0];
        ics_pkg::CFG_RUN_HDR_MASK: hdr_nxt     = wr_data[1:0];
        ics_pkg::CFG_FIXED_MASK:   fixed_nxt   = wr_data[1:0];
        ics_pkg::CFG_RX_EXP_SIZE:  rx_exp_nxt  = wr_data[15:0];
        ics_pkg::CFG_TX_EXP_SIZE:  tx_exp_nxt  = wr_data[15:0];
        default: ;
      endcase
    end
    // timeout threshold is kept as a product, refreshed on every write
    mul_a     = mult_nxt;
    mul_b     = consume_nxt;
    limit_nxt = {32'd0, mul_a} * {10'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r    <= '0;
      consume_r <= '0;
      produce_r <= '0;
      seq_r     <= 1'b0;
      hdr_r     <= 2'b00;
      fixed_r   <= 2'b11;
      rx_exp_r  <= '0;
      tx_exp_r  <= '0;
      limit_r   <= '0;
    end else begin
      mult_r    <= mult_nxt;
      consume_r <= consume_nxt;
      produce_r <= produce_nxt;
      seq_r     <= seq_nxt;
      hdr_r     <= hdr_nxt;
      fixed_r   <= fixed_nxt;
      rx_exp_r  <= rx_exp_nxt;
      tx_exp_r  <= tx_exp_nxt;
      if (wr_valid) begin
        limit_r <= limit_nxt;
      end
    end
  end

  always_comb begin
    cfg.timeout_limit    = limit_r;
    cfg.produce_interval = produce_r;
    cfg.seq_en           = seq_r;
    cfg.rx_hdr_en        = hdr_r[0];
    cfg.tx_hdr_en        = hdr_r[1];
    cfg.rx_fixed         = fixed_r[0];
    cfg.tx_fixed         = fixed_r[1];
    cfg.rx_expected_size = rx_exp_r;
    cfg.tx_expected_size = tx_exp_r;
  end

endmodule

>>> hdl/ics_engine.sv
`timescale 1ns / 1ps

module ics_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  ics_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  ics_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output ics_pkg::res_t  out_res
);

  typedef struct packed {
    logic                        command;
    logic [ics_pkg::MICRO_W-1:0] micro;
    logic [15:0]                 rx_total_length;
    logic [31:0]                 rx_run_header;
    logic [15:0]                 rx_seq_count;
    logic [15:0]                 tx_payload_length;
  } stage_t;

  logic          s0_v_r, s0_v_nxt;
  stage_t        s0_r;
  logic          out_v_r, out_v_nxt;
  ics_pkg::res_t res_r, res_nxt;
  logic          adv;
  logic          in_fire;

  logic [47:0] acc_r,   acc_nxt;
  logic [32:0] prod_r,  prod_nxt;
  logic [31:0] addr_r,  addr_nxt;
  logic [15:0] dseq_r,  dseq_nxt;

  logic [2:0]  overhead;
  logic        rx_short;
  logic [15:0] rx_payload;
  logic        rx_reject;
  logic [48:0] acc_sum;
  logic [47:0] acc_sat;
  logic        closed;
  logic [32:0] prod_sum;
  logic        produce;
  logic [31:0] addr_inc;
  logic [15:0] dseq_inc;

  // result register frees when empty or drained this cycle
  assign adv       = s0_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s0_v_r || adv;
  assign in_fire   = in_valid && in_ready;
  assign s0_v_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : s0_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_comb begin
    overhead   = {cfg.rx_hdr_en, 2'b00} | {1'b0, cfg.seq_en, 1'b0};
    rx_short   = s0_r.rx_total_length < {13'd0, overhead};
    rx_payload = s0_r.rx_total_length - {13'd0, overhead};
    rx_reject  = rx_short || (cfg.rx_fixed && (rx_payload != cfg.rx_expected_size));

    acc_sum  = {1'b0, acc_r} + {23'd0, s0_r.micro};
    acc_sat  = acc_sum[48] ? ics_pkg::ACC_MAX : acc_sum[47:0];
    closed   = acc_sat > {6'd0, cfg.timeout_limit};
    prod_sum = prod_r + {7'd0, s0_r.micro};
    produce  = prod_sum >= {1'b0, cfg.produce_interval};
    addr_inc = addr_r + 32'd1;
    dseq_inc = dseq_r + 16'd1;

    res_nxt       = '0;
    res_nxt.alive = 1'b1;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    addr_nxt      = addr_r;
    dseq_nxt      = dseq_r;

    if (s0_r.command == ics_pkg::CMD_FRAME) begin
      if (rx_reject) begin
        res_nxt.event_res = ics_pkg::EV_RX_REJECTED;
      end else begin
        acc_nxt                      = '0;
        res_nxt.event_res            = ics_pkg::EV_RX_ACCEPTED;
        res_nxt.payload_length       = rx_payload;
        res_nxt.delivered_run_header = cfg.rx_hdr_en ? s0_r.rx_run_header : 32'd0;
        res_nxt.delivered_seq_count  = cfg.seq_en ? s0_r.rx_seq_count : 16'd0;
      end
    end else begin
      acc_nxt = acc_sat;
      if (closed) begin
        res_nxt.event_res = ics_pkg::EV_CLOSED;
        res_nxt.alive     = 1'b0;
      end else if (!produce) begin
        prod_nxt          = prod_sum;
        res_nxt.event_res = ics_pkg::EV_TICK_IDLE;
      end else begin
        prod_nxt = '0;
        addr_nxt = addr_inc;
        if (cfg.seq_en) begin
          dseq_nxt = dseq_inc;
        end
        res_nxt.tx_sequence_number = addr_inc;
        res_nxt.tx_seq_count       = cfg.seq_en ? dseq_inc : 16'd0;
        res_nxt.tx_count_present   = cfg.seq_en;
        res_nxt.tx_header_present  = cfg.tx_hdr_en;
        // size mismatch still burns a sequence number
        if (cfg.tx_fixed && (s0_r.tx_payload_length != cfg.tx_expected_size)) begin
          res_nxt.event_res = ics_pkg::EV_TX_SUPPRESS;
        end else begin
          res_nxt.event_res = ics_pkg::EV_TX_SENT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= '0;
      prod_r  <= '0;
      addr_r  <= '0;
      dseq_r  <= '0;
    end else begin
      s0_v_r  <= s0_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        acc_r  <= acc_nxt;
        prod_r <= prod_nxt;
        addr_r <= addr_nxt;
        dseq_r <= dseq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_r.command           <= in_item.command;
      s0_r.micro             <= ics_pkg::MICRO_W'({10'd0, in_item.period_ms} *
                                                  {16'd0, ics_pkg::US_PER_MS});
      s0_r.rx_total_length   <= in_item.rx_total_length;
      s0_r.rx_run_header     <= in_item.rx_run_header;
      s0_r.rx_seq_count      <= in_item.rx_seq_count;
      s0_r.tx_payload_length <= in_item.tx_payload_length;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;

endmodule

>>> hdl/io_connection_supervisor.sv
`timescale 1ns / 1ps

// Supervisor for one cyclic I/O connection: every beat on in_ch is a tick or a
// received frame and yields exactly one result beat on out_ch. One item is taken
// per clock unless out_ch stalls a full result register. An input register
// converts the tick to microseconds, then one add-and-compare pass updates the
// timers and sequence counters and loads the result register.
// The timeout threshold, multiplier times consume interval, is multiplied once
// when a configuration register is written, so an item may follow the last
// write on the next cycle. cfg_ch is always ready.
module io_connection_supervisor (
  input logic      clk,
  input logic      rst_n,
  ics_in_if.sink   in_ch,
  ics_out_if.source out_ch,
  ics_cfg_if.sink  cfg_ch
);

  ics_pkg::cfg_t  cfg;
  ics_pkg::item_t in_item;
  ics_pkg::res_t  out_res;

  always_comb begin
    in_item.command           = in_ch.command;
    in_item.period_ms         = in_ch.period_ms;
    in_item.rx_total_length   = in_ch.rx_total_length;
    in_item.rx_run_header     = in_ch.rx_run_header;
    in_item.rx_seq_count      = in_ch.rx_seq_count;
    in_item.tx_payload_length = in_ch.tx_payload_length;
  end

  ics_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  ics_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.event_res            = out_res.event_res;
  assign out_ch.alive                = out_res.alive;
  assign out_ch.payload_length       = out_res.payload_length;
  assign out_ch.delivered_run_header = out_res.delivered_run_header;
  assign out_ch.delivered_seq_count  = out_res.delivered_seq_count;
  assign out_ch.tx_sequence_number   = out_res.tx_sequence_number;
  assign out_ch.tx_seq_count         = out_res.tx_seq_count;
  assign out_ch.tx_count_present     = out_res.tx_count_present;
  assign out_ch.tx_header_present    = out_res.tx_header_present;

endmodule

>>> hdl/ics_checker.sv
`timescale 1ns / 1ps

module ics_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_res,
  input logic        alive,
  input logic [15:0] payload_length,
  input logic [31:0] delivered_run_header,
  input logic [15:0] delivered_seq_count,
  input logic [31:0] tx_sequence_number,
  input logic [15:0] tx_seq_count,
  input logic        tx_count_present,
  input logic        tx_header_present
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // alive low marks a timeout close and nothing else
  a_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((alive == 1'b0) == (event_res == ics_pkg::EV_CLOSED)))
    else $error("alive disagrees with event");

  // receive fields only on accepted frames
  a_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res != ics_pkg::EV_RX_ACCEPTED) |->
      (payload_length == 16'd0) && (delivered_run_header == 32'd0) &&
      (delivered_seq_count == 16'd0))
    else $error("receive fields set outside accepted frame");

  // send fields only on send or suppress
  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res != ics_pkg::EV_TX_SENT) &&
      (event_res != ics_pkg::EV_TX_SUPPRESS) |->
      (tx_sequence_number == 32'd0) && (tx_seq_count == 16'd0) &&
      !tx_count_present && !tx_header_present)
    else $error("send fields set outside send event");

endmodule

bind io_connection_supervisor ics_checker u_ics_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .event_res            (out_ch.event_res),
  .alive                (out_ch.alive),
  .payload_length       (out_ch.payload_length),
  .delivered_run_header (out_ch.delivered_run_header),
  .delivered_seq_count  (out_ch.delivered_seq_count),
  .tx_sequence_number   (out_ch.tx_sequence_number),
  .tx_seq_count         (out_ch.tx_seq_count),
  .tx_count_present     (out_ch.tx_count_present),
  .tx_header_present    (out_ch.tx_header_present)
);
